// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms used by the rtl top module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/jrf_pkg.sv -----
// ----------------------------------------------------------------------------
// jrf_pkg
// types, register indexes and reset values for the joystick report filter
// ----------------------------------------------------------------------------
`default_nettype none

package jrf_pkg;

  localparam int AXIS_W   = 16;
  localparam int DZ_W     = 15;
  localparam int TOL_W    = 16;
  localparam int PERIOD_W = 16;
  localparam int BTN_W    = 8;
  localparam int TIME_W   = 32;
  localparam int SEQ_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DZ_FIRST      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DZ_SECOND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TOL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_INTVL_MS = 3'd4;

  // reset values: 0.12, 0.10, 0.05 in q15; 1000/2 and 1000/10 ms
  localparam logic [DZ_W-1:0]     RST_DZ_FIRST      = 15'd3932;
  localparam logic [DZ_W-1:0]     RST_DZ_SECOND     = 15'd3277;
  localparam logic [TOL_W-1:0]    RST_MOVE_TOL      = 16'd1638;
  localparam logic [PERIOD_W-1:0] RST_HEARTBEAT_MS  = 16'd500;
  localparam logic [PERIOD_W-1:0] RST_MOVE_INTVL_MS = 16'd100;

  typedef struct packed {
    logic [DZ_W-1:0]     dz_first;
    logic [DZ_W-1:0]     dz_second;
    logic [TOL_W-1:0]    move_tol;
    logic [PERIOD_W-1:0] heartbeat_ms;
    logic [PERIOD_W-1:0] move_intvl_ms;
  } jrf_cfg_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] last_axis_z;
    logic signed [AXIS_W-1:0] last_axis_x;
    logic [BTN_W-1:0]         last_buttons;
    logic [TIME_W-1:0]        last_time;
    logic [SEQ_W-1:0]         next_seq;
  } jrf_state_t;

  typedef struct packed {
    logic                     fwd;
    logic signed [AXIS_W-1:0] axis_z;
    logic signed [AXIS_W-1:0] axis_x;
  } jrf_dec_t;

endpackage

`default_nettype wire

// ----- rtl/core/jrf_decide.sv -----
// ----------------------------------------------------------------------------
// jrf_decide
// deadzone on both axes and the forward decision against the last report
// ----------------------------------------------------------------------------
`default_nettype none

module jrf_decide import jrf_pkg::*; (
  input  jrf_cfg_t                 cfg,
  input  jrf_state_t               st,
  input  logic signed [AXIS_W-1:0] axis_z,
  input  logic signed [AXIS_W-1:0] axis_x,
  input  logic [BTN_W-1:0]         buttons,
  input  logic [TIME_W-1:0]        time_ms,
  output jrf_dec_t                 dec
);

  // magnitude of a 17-bit signed value, exact in 17 bits for these ranges
  function automatic logic [AXIS_W:0] mag17(input logic signed [AXIS_W:0] v);
    logic signed [AXIS_W:0] neg;
    neg = -v;
    return v[AXIS_W] ? neg : v;
  endfunction

  logic [AXIS_W:0]          mag_z;
  logic [AXIS_W:0]          mag_x;
  logic signed [AXIS_W-1:0] dz_z;
  logic signed [AXIS_W-1:0] dz_x;
  logic signed [AXIS_W:0]   diff_z;
  logic signed [AXIS_W:0]   diff_x;
  logic [TIME_W-1:0]        elapsed;
  logic                     btn_chg;
  logic                     to_center;
  logic                     heartbeat;
  logic                     moved;

  always_comb begin
    mag_z = mag17({axis_z[AXIS_W-1], axis_z});
    mag_x = mag17({axis_x[AXIS_W-1], axis_x});
    dz_z  = (mag_z < {2'b00, cfg.dz_first}) ? '0 : axis_z;
    dz_x  = (mag_x < {2'b00, cfg.dz_second}) ? '0 : axis_x;

    diff_z  = {dz_z[AXIS_W-1], dz_z} - {st.last_axis_z[AXIS_W-1], st.last_axis_z};
    diff_x  = {dz_x[AXIS_W-1], dz_x} - {st.last_axis_x[AXIS_W-1], st.last_axis_x};
    elapsed = time_ms - st.last_time;

    btn_chg   = (buttons != st.last_buttons);
    to_center = (dz_z == '0) && (dz_x == '0) &&
                ((st.last_axis_z != '0) || (st.last_axis_x != '0));
    heartbeat = (elapsed > {16'd0, cfg.heartbeat_ms});
    moved     = (elapsed > {16'd0, cfg.move_intvl_ms}) &&
                ((mag17(diff_z) > {1'b0, cfg.move_tol}) ||
                 (mag17(diff_x) > {1'b0, cfg.move_tol}));

    dec.fwd    = btn_chg || to_center || heartbeat || moved;
    dec.axis_z = dz_z;
    dec.axis_x = dz_x;
  end

endmodule

`default_nettype wire

// ----- rtl/core/joystick_report_filter_top.sv -----
// ----------------------------------------------------------------------------
// joystick_report_filter_top
// deadzone and change filter for joystick reports
// ----------------------------------------------------------------------------
// usage:
//   in_* channel carries one report per transaction (two q15 axes, buttons,
//   millisecond timestamp). out_* channel carries a forwarded report with
//   its sequence number; reports that change nothing are dropped.
//   cfg_* is a write-only register port; the user must write it only while
//   the block is idle, and the block itself does not enforce this.
// throughput: one report per cycle while out_stall is low; a report is
//   registered on accept, decided combinationally with the last-report
//   update, and registered into the output register as the stage advances.
// stall: the output register holds while out_stall is high; the input
//   register still takes a report while the output register is empty or
//   draining, and in_stall rises only when both are full and stalled.
// reset: rst_n low clears both stages, the last-report state and the
//   sequence counter, and loads the default register values.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module joystick_report_filter_top import jrf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [AXIS_W-1:0] in_axis_z,
  input  logic signed [AXIS_W-1:0] in_axis_x,
  input  logic [BTN_W-1:0]         in_button_bits,
  input  logic [TIME_W-1:0]        in_time_ms,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [AXIS_W-1:0] out_axis_z,
  output logic signed [AXIS_W-1:0] out_axis_x,
  output logic [BTN_W-1:0]         out_buttons,
  output logic [SEQ_W-1:0]         out_sequence_res,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  jrf_cfg_t   cfg_r, cfg_nxt;
  jrf_state_t st_r, st_nxt;
  jrf_dec_t   dec;

  logic                     s1_valid_r, s1_valid_nxt;
  logic signed [AXIS_W-1:0] s1_axis_z_r;
  logic signed [AXIS_W-1:0] s1_axis_x_r;
  logic [BTN_W-1:0]         s1_buttons_r;
  logic [TIME_W-1:0]        s1_time_r;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [AXIS_W-1:0] out_axis_z_r;
  logic signed [AXIS_W-1:0] out_axis_x_r;
  logic [BTN_W-1:0]         out_buttons_r;
  logic [SEQ_W-1:0]         out_seq_r;

  logic in_take;
  logic advance;
  logic emit;

  // config registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DZ_FIRST:      cfg_nxt.dz_first      = cfg_wdata[DZ_W-1:0];
        CFG_DZ_SECOND:     cfg_nxt.dz_second     = cfg_wdata[DZ_W-1:0];
        CFG_MOVE_TOL:      cfg_nxt.move_tol      = cfg_wdata[TOL_W-1:0];
        CFG_HEARTBEAT_MS:  cfg_nxt.heartbeat_ms  = cfg_wdata[PERIOD_W-1:0];
        CFG_MOVE_INTVL_MS: cfg_nxt.move_intvl_ms = cfg_wdata[PERIOD_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  jrf_decide u_decide (
    .cfg     (cfg_r),
    .st      (st_r),
    .axis_z  (s1_axis_z_r),
    .axis_x  (s1_axis_x_r),
    .buttons (s1_buttons_r),
    .time_ms (s1_time_r),
    .dec     (dec)
  );

  // handshake and stage control
  always_comb begin
    advance      = s1_valid_r && (!out_valid_r || !out_stall);
    emit         = advance && dec.fwd;
    in_stall     = s1_valid_r && !advance;
    in_take      = in_valid && !in_stall;
    s1_valid_nxt = in_take || (s1_valid_r && !advance);
    out_valid_nxt = advance ? dec.fwd : (out_valid_r && out_stall);

    st_nxt = st_r;
    if (emit) begin
      st_nxt.last_axis_z  = dec.axis_z;
      st_nxt.last_axis_x  = dec.axis_x;
      st_nxt.last_buttons = s1_buttons_r;
      st_nxt.last_time    = s1_time_r;
      st_nxt.next_seq     = st_r.next_seq + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dz_first      <= RST_DZ_FIRST;
      cfg_r.dz_second     <= RST_DZ_SECOND;
      cfg_r.move_tol      <= RST_MOVE_TOL;
      cfg_r.heartbeat_ms  <= RST_HEARTBEAT_MS;
      cfg_r.move_intvl_ms <= RST_MOVE_INTVL_MS;
      st_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      st_r        <= st_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_axis_z_r  <= in_axis_z;
      s1_axis_x_r  <= in_axis_x;
      s1_buttons_r <= in_button_bits;
      s1_time_r    <= in_time_ms;
    end
    if (emit) begin
      out_axis_z_r  <= dec.axis_z;
      out_axis_x_r  <= dec.axis_x;
      out_buttons_r <= s1_buttons_r;
      out_seq_r     <= st_r.next_seq;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_axis_z       = out_axis_z_r;
  assign out_axis_x       = out_axis_x_r;
  assign out_buttons      = out_buttons_r;
  assign out_sequence_res = out_seq_r;

  `ASSERT_IMPL(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r, "stall with no held item")
  `ASSERT_NEXT(a_seq_step, clk, rst_n, emit, st_r.next_seq == $past(st_r.next_seq) + 1, "seq step")
  `ASSERT_NEXT(a_state_hold, clk, rst_n, !emit, st_r == $past(st_r), "state changed")
  `ASSERT_NEXT(a_out_valid, clk, rst_n, emit, out_valid_r, "forward not presented")
  `ASSERT_NEXT(a_out_seq, clk, rst_n, emit, out_seq_r == $past(st_r.next_seq), "bad out seq")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// testbench for joystick_report_filter_top: reports are driven through the
// input channel under random idling, a local copy of the deadzone and change
// filter predicts which reports are forwarded, and every forwarded report is
// compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb;
  import jrf_pkg::*;

  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    logic signed [AXIS_W-1:0] axis_z;
    logic signed [AXIS_W-1:0] axis_x;
    logic [BTN_W-1:0]         buttons;
    logic [SEQ_W-1:0]         seq;
  } report_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [AXIS_W-1:0] in_axis_z = '0;
  logic signed [AXIS_W-1:0] in_axis_x = '0;
  logic [BTN_W-1:0]         in_button_bits = '0;
  logic [TIME_W-1:0]        in_time_ms = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [AXIS_W-1:0] out_axis_z;
  logic signed [AXIS_W-1:0] out_axis_x;
  logic [BTN_W-1:0]         out_buttons;
  logic [SEQ_W-1:0]         out_sequence_res;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

  // forwarded reports still to come
  report_t forwarded_reports[$];

  // filter settings and last forwarded report as the block should hold them
  jrf_cfg_t                 filter_cfg;
  logic signed [AXIS_W-1:0] held_z;
  logic signed [AXIS_W-1:0] held_x;
  logic [BTN_W-1:0]         held_btn;
  logic [TIME_W-1:0]        held_time;
  logic [SEQ_W-1:0]         seq_next;

  // last report sent
  logic signed [AXIS_W-1:0] cur_z = '0;
  logic signed [AXIS_W-1:0] cur_x = '0;
  logic [BTN_W-1:0]         cur_btn = '0;
  logic [TIME_W-1:0]        cur_time = '0;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  joystick_report_filter_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_axis_z        (in_axis_z),
    .in_axis_x        (in_axis_x),
    .in_button_bits   (in_button_bits),
    .in_time_ms       (in_time_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_axis_z       (out_axis_z),
    .out_axis_x       (out_axis_x),
    .out_buttons      (out_buttons),
    .out_sequence_res (out_sequence_res),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic int unsigned mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic filter_report(input logic signed [AXIS_W-1:0] raw_z, raw_x,
                               input logic [BTN_W-1:0] btn, input logic [TIME_W-1:0] now);
    logic signed [AXIS_W-1:0] z;
    logic signed [AXIS_W-1:0] x;
    logic [TIME_W-1:0]        elapsed;
    logic                     moved;
    z = (mag(int'(raw_z)) < filter_cfg.dz_first) ? '0 : raw_z;
    x = (mag(int'(raw_x)) < filter_cfg.dz_second) ? '0 : raw_x;
    elapsed = now - held_time;
    moved = (mag(int'(z) - int'(held_z)) > filter_cfg.move_tol) ||
            (mag(int'(x) - int'(held_x)) > filter_cfg.move_tol);
    if (btn != held_btn || (z == 0 && x == 0 && (held_z != 0 || held_x != 0)) ||
        elapsed > filter_cfg.heartbeat_ms || (elapsed > filter_cfg.move_intvl_ms && moved)) begin
      forwarded_reports.push_back('{z, x, btn, seq_next});
      held_z = z;
      held_x = x;
      held_btn = btn;
      held_time = now;
      seq_next = seq_next + 1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_report();
    report_t want;
    if (forwarded_reports.size() == 0) begin
      $display("%0t: unexpected transaction expected none actual %h %h %h %h", $time,
               out_axis_z, out_axis_x, out_buttons, out_sequence_res);
      errors++;
    end else begin
      want = forwarded_reports.pop_front();
      check_field("axis_z", 32'(want.axis_z), 32'(out_axis_z));
      check_field("axis_x", 32'(want.axis_x), 32'(out_axis_x));
      check_field("buttons", 32'(want.buttons), 32'(out_buttons));
      check_field("sequence", want.seq, out_sequence_res);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_report();
      if (in_valid && !in_stall) filter_report(in_axis_z, in_axis_x, in_button_bits, in_time_ms);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("joystick_report_filter_top verification failed");
      $finish;
    end
  end

  task automatic send_report(input logic signed [AXIS_W-1:0] z, x,
                             input logic [BTN_W-1:0] btn, input logic [TIME_W-1:0] t);
    in_valid <= 1'b1;
    in_axis_z <= z;
    in_axis_x <= x;
    in_button_bits <= btn;
    in_time_ms <= t;
    cur_z = z;
    cur_x = x;
    cur_btn = btn;
    cur_time = t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (forwarded_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // caller lowers cfg_wr_en after the last write of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_DZ_FIRST:      filter_cfg.dz_first = data[DZ_W-1:0];
      CFG_DZ_SECOND:     filter_cfg.dz_second = data[DZ_W-1:0];
      CFG_MOVE_TOL:      filter_cfg.move_tol = data[TOL_W-1:0];
      CFG_HEARTBEAT_MS:  filter_cfg.heartbeat_ms = data[PERIOD_W-1:0];
      CFG_MOVE_INTVL_MS: filter_cfg.move_intvl_ms = data[PERIOD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] dz_z, dz_x, jit, hb, mv);
    write_reg(CFG_DZ_FIRST, dz_z);
    write_reg(CFG_DZ_SECOND, dz_x);
    write_reg(CFG_MOVE_TOL, jit);
    write_reg(CFG_HEARTBEAT_MS, hb);
    write_reg(CFG_MOVE_INTVL_MS, mv);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_setting(input int extreme, input int typical);
    case ($urandom_range(5))
      0: return '0;
      1: return CFG_DATA_W'(extreme);
      default: return CFG_DATA_W'($urandom_range(0, typical));
    endcase
  endfunction

  function automatic logic [AXIS_W-1:0] pick_axis(input int cur, input int dz);
    int m;
    m = dz + int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(5))
      0: return '0;
      1: return AXIS_W'($urandom_range(1) ? m : -m);
      2: return AXIS_W'(cur + int'($urandom_range(0, 4000)) - 2000);
      3: return AXIS_W'($urandom);
      4: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return AXIS_W'(cur);
    endcase
  endfunction

  task automatic random_report();
    logic [TIME_W-1:0] t;
    logic [BTN_W-1:0]  b;
    case ($urandom_range(7))
      0: t = cur_time;
      6: t = cur_time + $urandom_range(0, 70000);
      7: t = $urandom;
      default: t = cur_time + $urandom_range(0, 600);
    endcase
    case ($urandom_range(9))
      0, 1: b = cur_btn ^ (8'h01 << $urandom_range(0, 7));
      2: b = BTN_W'($urandom);
      default: b = cur_btn;
    endcase
    send_report(pick_axis(int'(cur_z), int'(filter_cfg.dz_first)),
                pick_axis(int'(cur_x), int'(filter_cfg.dz_second)), b, t);
  endtask

  task automatic randomize_config();
    set_config(pick_setting(32767, 6000), pick_setting(32767, 6000), pick_setting(65535, 3000),
               pick_setting(65535, 1000), pick_setting(65535, 300));
  endtask

  // default settings straight after reset
  task automatic test_directed_filtering();
    send_report(0, 0, 8'h00, 0);
    send_report(0, 0, 8'h01, 10);
    send_report(0, 0, 8'h80, 20);
    send_report(3931, -3276, 8'h80, 30);
    send_report(3932, -3277, 8'h80, 60);
    send_report(3932, -3277, 8'h80, 200);
    send_report(-3931, 3276, 8'h80, 210);
    send_report(-32768, 32767, 8'h80, 311);
    send_report(-32768, 32767, 8'h80, 811);
    send_report(-32768, 32767, 8'h80, 812);
    send_report(-31768, 32767, 8'h80, 913);
    send_report(-31129, 32767, 8'h80, 914);
    send_report(-29491, 32767, 8'h80, 1100);
    send_report(0, 0, 8'hFF, 32'hFFFF_FFF0);
    send_report(0, 0, 8'hFF, 32'h0000_0010);
    send_report(0, 0, 8'hFF, 32'h0000_0300);
    send_report(32767, -32768, 8'h55, 32'h0000_0301);
    send_report(32767, -32768, 8'hAA, 32'hFFFF_FFFF);
    send_report(0, 0, 8'h00, 32'hFFFF_FFFF);
    send_report(-1, 1, 8'h00, 32'hFFFF_FFFF);
    drain_reports();
  endtask

  task automatic test_register_extremes();
    // zero deadzones, tolerance and periods
    set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_report(1, -1, cur_btn, cur_time);
    send_report(1, -1, cur_btn, cur_time);
    send_report(1, -1, cur_btn, cur_time + 1);
    send_report(2, -1, cur_btn, cur_time);
    repeat (20) random_report();
    drain_reports();
    // widest values, deadzone bit 15 dropped
    set_config(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_report(-32768, 32767, cur_btn ^ 8'h0F, cur_time);
    send_report(32766, -32767, cur_btn, cur_time);
    send_report(32767, -32768, cur_btn ^ 8'hF0, cur_time + 32'h0001_0000);
    repeat (20) random_report();
    drain_reports();
    // unused indexes are ignored
    for (int i = int'(CFG_MOVE_INTVL_MS) + 1; i < 2 ** CFG_IDX_W; i++) begin
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    repeat (10) random_report();
    drain_reports();
    set_config(CFG_DATA_W'(RST_DZ_FIRST), CFG_DATA_W'(RST_DZ_SECOND), RST_MOVE_TOL,
               RST_HEARTBEAT_MS, RST_MOVE_INTVL_MS);
    repeat (10) random_report();
    drain_reports();
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    randomize_config();
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        drain_reports();
        randomize_config();
      end
      random_report();
    end
    drain_reports();
  endtask

  initial begin
    filter_cfg = '{RST_DZ_FIRST, RST_DZ_SECOND, RST_MOVE_TOL, RST_HEARTBEAT_MS,
                   RST_MOVE_INTVL_MS};
    held_z = '0;
    held_x = '0;
    held_btn = '0;
    held_time = '0;
    seq_next = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_filtering();
    test_register_extremes();
    test_random_traffic(240, 0, 0);
    test_random_traffic(240, 63, 0);
    test_random_traffic(240, 0, 63);
    test_random_traffic(240, 31, 31);
    drain_reports();
    if (errors == 0 && forwarded_reports.size() == 0) begin
      $display("joystick_report_filter_top verification clean");
    end else begin
      $display("joystick_report_filter_top verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/jrf_pkg.sv
rtl/core/jrf_decide.sv
rtl/core/joystick_report_filter_top.sv
bench/tb.sv
